// ===== src/dvru_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the distance-vector route table.
// Used by the RAM wrapper users, the controller, the datapath, the top level and the checker.
package dvru_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Field widths.
  localparam int ADDR_W  = 32;
  localparam int COST_W  = 8;
  localparam int PURGE_W = 6;
  localparam logic [PURGE_W-1:0] PURGE_MAX = '1;

  // Configuration port.
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_COST_LIMIT = '0;
  localparam logic [COST_W-1:0] COST_LIMIT_RESET = 8'd16;

  // Item kinds.
  localparam logic [1:0] KIND_RELAX  = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_PURGE  = 2'd2;

  // Outcome codes.
  localparam logic [2:0] OC_UNCHANGED = 3'd0;
  localparam logic [2:0] OC_UPDATED   = 3'd1;
  localparam logic [2:0] OC_REPLACED  = 3'd2;
  localparam logic [2:0] OC_INSERTED  = 3'd3;
  localparam logic [2:0] OC_FULL      = 3'd4;
  localparam logic [2:0] OC_HIT       = 3'd5;
  localparam logic [2:0] OC_MISS      = 3'd6;
  localparam logic [2:0] OC_PURGED    = 3'd7;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] neighbor_addr;
    logic [COST_W-1:0] link_metric;
    logic [ADDR_W-1:0] dest_addr;
    logic [COST_W-1:0] advertised_distance;
  } dvru_req_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic               changed;
    logic [ADDR_W-1:0]  next_hop_addr;
    logic [COST_W-1:0]  route_cost;
    logic [PURGE_W-1:0] purged_count;
  } dvru_rsp_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] next_hop;
    logic [COST_W-1:0] cost;
  } dvru_entry_t;

  localparam int ENTRY_W = $bits(dvru_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             clr_wr;
    logic             rd_en;
    logic             finish;
    logic [IDX_W-1:0] addr;
  } dvru_cmd_t;

endpackage

// ===== src/dvru_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dvru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/dvru_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the route table: clearing pass, table scan and finish sequencing.
// Depends on dvru_pkg.
module dvru_ctrl
  import dvru_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output dvru_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] addr_next;

  always_comb begin
    state_next = state;
    addr_next  = addr;
    cmd        = '0;
    cmd.addr   = addr;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (addr == LAST_IDX) begin
          state_next = S_IDLE;
          addr_next  = '0;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
          addr_next  = '0;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (addr == LAST_IDX) begin
          state_next = S_FLUSH;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      S_FLUSH: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== src/dvru_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the route table: entry RAM, match and free-slot tracking, purge and write-back.
// Depends on dvru_pkg and dvru_ram.
module dvru_datapath
  import dvru_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dvru_cmd_t         cmd,
  input  dvru_req_t         req,
  input  logic [COST_W-1:0] cost_limit,
  output logic              done,
  output dvru_rsp_t         rsp
);

  dvru_req_t          item;
  logic               cmp_en;
  logic [IDX_W-1:0]   cmp_idx;
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [ADDR_W-1:0]  hit_hop;
  logic [COST_W-1:0]  hit_cost;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [PURGE_W-1:0] purge_cnt;

  dvru_entry_t        rd_word;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  dvru_entry_t        wdata;

  logic               is_match;
  logic               is_stale;
  logic [COST_W:0]    sum;
  logic [COST_W-1:0]  sat;
  logic               fin_we;
  logic [IDX_W-1:0]   fin_idx;
  dvru_entry_t        fin_word;
  dvru_rsp_t          rsp_next;

  dvru_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(cmd.addr),
    .rdata(rd_word)
  );

  assign is_match = cmp_en && rd_word.valid && (rd_word.dest == item.dest_addr);
  assign is_stale = cmp_en && (item.kind == KIND_PURGE) && rd_word.valid &&
                    (rd_word.cost >= cost_limit);

  assign sum = {1'b0, item.link_metric} + {1'b0, item.advertised_distance};
  assign sat = (sum > {1'b0, cost_limit}) ? cost_limit : sum[COST_W-1:0];

  // Outcome of the item once the whole table has been seen.
  always_comb begin
    rsp_next          = '0;
    fin_we            = 1'b0;
    fin_idx           = hit_idx;
    fin_word.valid    = 1'b1;
    fin_word.dest     = item.dest_addr;
    fin_word.next_hop = hit_hop;
    fin_word.cost     = sat;
    case (item.kind)
      KIND_RELAX: begin
        if (hit_found) begin
          rsp_next.route_cost = hit_cost;
          if (hit_hop == item.neighbor_addr) begin
            if (sat != hit_cost) begin
              fin_we              = 1'b1;
              rsp_next.outcome    = OC_UPDATED;
              rsp_next.changed    = 1'b1;
              rsp_next.route_cost = sat;
            end
          end else if (sum < {1'b0, hit_cost}) begin
            fin_we              = 1'b1;
            fin_word.next_hop   = item.neighbor_addr;
            rsp_next.outcome    = OC_REPLACED;
            rsp_next.changed    = 1'b1;
            rsp_next.route_cost = sat;
          end
        end else if (sum < {1'b0, cost_limit}) begin
          if (free_found) begin
            fin_we              = 1'b1;
            fin_idx             = free_idx;
            fin_word.next_hop   = item.neighbor_addr;
            fin_word.cost       = sum[COST_W-1:0];
            rsp_next.outcome    = OC_INSERTED;
            rsp_next.changed    = 1'b1;
            rsp_next.route_cost = sum[COST_W-1:0];
          end else begin
            rsp_next.outcome = OC_FULL;
          end
        end
      end
      KIND_LOOKUP: begin
        if (hit_found) begin
          rsp_next.outcome       = OC_HIT;
          rsp_next.next_hop_addr = hit_hop;
          rsp_next.route_cost    = hit_cost;
        end else begin
          rsp_next.outcome = OC_MISS;
        end
      end
      KIND_PURGE: begin
        rsp_next.outcome      = OC_PURGED;
        rsp_next.changed      = (purge_cnt != '0);
        rsp_next.purged_count = purge_cnt;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  // Only one writer is active in any cycle: the clearing pass, a purge during the
  // scan, or the write-back in the finish cycle.
  always_comb begin
    we    = 1'b0;
    waddr = cmd.addr;
    wdata = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (is_stale) begin
      we          = 1'b1;
      waddr       = cmp_idx;
      wdata       = rd_word;
      wdata.valid = 1'b0;
    end else if (cmd.finish && fin_we) begin
      we    = 1'b1;
      waddr = fin_idx;
      wdata = fin_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
      done   <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_en;
      done   <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cmd.addr;
    if (cmd.load) begin
      item       <= req;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      purge_cnt  <= '0;
    end else if (cmp_en) begin
      if (is_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_hop   <= rd_word.next_hop;
        hit_cost  <= rd_word.cost;
      end
      if (!rd_word.valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (is_stale && (purge_cnt != PURGE_MAX)) begin
        purge_cnt <= purge_cnt + 1'b1;
      end
    end
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/distance_vector_route_update.sv =====
`timescale 1ns / 1ps
// Top level of the distance-vector route table: configuration register, controller and datapath.
// Depends on dvru_pkg, dvru_ctrl and dvru_datapath (which holds dvru_ram).
//
//   Channel   Ports                                    Word accepted when
//   -------   --------------------------------------   ----------------------------------
//   item      start, busy, req                         start high and busy low at the edge
//   result    done, rsp                                done high (one cycle, cannot stall)
//   config    psel, penable, pwrite, paddr, pwdata,    psel, penable, pwrite and pready
//             prdata, pready                           high at the edge
//
// After reset the block runs a clearing pass that marks every entry invalid; busy stays
// high meanwhile, while configuration writes are taken as usual.
// Every item walks the whole entry RAM, one entry per cycle through its single read port,
// then passes a flush state for the last compare and a finish state for the write-back.
// The block takes no new item until it has finished the last one. busy drops in the cycle
// in which done is shown, so the next item may be accepted alongside that result.
// The result receiver has no way to stall the block.
module distance_vector_route_update
  import dvru_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dvru_req_t          req,
  output logic               done,
  output dvru_rsp_t          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [COST_W-1:0] cost_limit;
  logic              cfg_wr;
  dvru_cmd_t         cmd;

  // The APB port never inserts wait states. Only the cost limit register is decoded;
  // writes to any other address are dropped and reads there return zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_COST_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_limit <= COST_LIMIT_RESET;
    end else if (cfg_wr) begin
      cost_limit <= pwdata[COST_W-1:0];
    end
  end

  assign prdata = (paddr == REG_COST_LIMIT) ? {{(PDATA_W - COST_W){1'b0}}, cost_limit}
                                            : '0;

  // The controller sequences the clearing pass and the per-item table scan.
  dvru_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  // The datapath holds the table, tracks the first match and the first free slot
  // during the scan, removes unreachable routes on a purge, and forms the result word.
  dvru_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cost_limit(cost_limit),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

// ===== src/dvru_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the distance-vector route table, bound to the top level.
// Depends on dvru_pkg and distance_vector_route_update.
module dvru_checker
  import dvru_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input dvru_rsp_t rsp
);

  // An accepted word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A result word is only shown once the block has gone idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && !$past(done)))
    else $error("result shown while busy or on consecutive cycles");

  // Only a purge reports a purge count.
  a_purge_count: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.outcome != OC_PURGED)) |-> (rsp.purged_count == '0))
    else $error("purge count on a non-purge result");

  // Outcomes that leave the table alone never flag a change.
  a_no_change: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.outcome == OC_UNCHANGED || rsp.outcome == OC_FULL ||
              rsp.outcome == OC_HIT || rsp.outcome == OC_MISS)) |-> !rsp.changed)
    else $error("change flagged on an outcome that leaves the table alone");

endmodule

bind distance_vector_route_update dvru_checker u_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the distance-vector route table (distance_vector_route_update).
// Depends on dvru_pkg and the RTL; a scoreboard class predicts every result word.

module tb_top
  import dvru_pkg::*;
();

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         DEST_POOL    = 40;
  localparam int         HOP_POOL     = 6;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 40;

  // Scoreboard: a private copy of the route table and of the cost limit. Each accepted
  // item is applied to it at once, and the expected word waits in a queue for the block.
  class route_table_scoreboard;
    bit [COST_W-1:0] cost_limit = COST_LIMIT_RESET;
    bit              entry_valid [TABLE_ENTRIES];
    bit [ADDR_W-1:0] entry_dest [TABLE_ENTRIES];
    bit [ADDR_W-1:0] entry_next_hop [TABLE_ENTRIES];
    bit [COST_W-1:0] entry_cost [TABLE_ENTRIES];
    dvru_rsp_t       pending_results[$];
    int              fail_count = 0;

    task report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
      fail_count++;
    endtask

    function int find_dest(bit [ADDR_W-1:0] d);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (entry_valid[i] && entry_dest[i] == d) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (!entry_valid[i]) return i;
      return -1;
    endfunction

    // Applies one item to the table copy and returns the word the block must give.
    function dvru_rsp_t route_table_update(dvru_req_t r);
      dvru_rsp_t   o;
      bit [COST_W:0]   sum;
      bit [COST_W-1:0] sat;
      int          t;
      int          f;
      o = '0;
      o.outcome = OC_UNCHANGED;
      case (r.kind)
        KIND_RELAX: begin
          // The sum is one bit wider than a cost, so it never wraps.
          sum = {1'b0, r.link_metric} + {1'b0, r.advertised_distance};
          sat = (sum > {1'b0, cost_limit}) ? cost_limit : sum[COST_W-1:0];
          t = find_dest(r.dest_addr);
          if (t >= 0) begin
            if (entry_next_hop[t] == r.neighbor_addr) begin
              if (sat != entry_cost[t]) begin
                entry_cost[t] = sat;
                o.outcome = OC_UPDATED;
                o.changed = 1'b1;
              end
            end else if (sum < {1'b0, entry_cost[t]}) begin
              entry_next_hop[t] = r.neighbor_addr;
              entry_cost[t] = sat;
              o.outcome = OC_REPLACED;
              o.changed = 1'b1;
            end
            o.route_cost = entry_cost[t];
          end else if (sum < {1'b0, cost_limit}) begin
            f = find_free();
            if (f >= 0) begin
              entry_valid[f] = 1'b1;
              entry_dest[f] = r.dest_addr;
              entry_next_hop[f] = r.neighbor_addr;
              entry_cost[f] = sum[COST_W-1:0];
              o.outcome = OC_INSERTED;
              o.changed = 1'b1;
              o.route_cost = sum[COST_W-1:0];
            end else begin
              o.outcome = OC_FULL;
            end
          end
        end
        KIND_LOOKUP: begin
          t = find_dest(r.dest_addr);
          if (t >= 0) begin
            o.outcome = OC_HIT;
            o.next_hop_addr = entry_next_hop[t];
            o.route_cost = entry_cost[t];
          end else begin
            o.outcome = OC_MISS;
          end
        end
        KIND_PURGE: begin
          // Costs are compared as plain numbers, so entries above a lowered limit go too.
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (entry_valid[i] && entry_cost[i] >= cost_limit) begin
              entry_valid[i] = 1'b0;
              if (o.purged_count != PURGE_MAX) o.purged_count++;
              o.changed = 1'b1;
            end
          end
          o.outcome = OC_PURGED;
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_item(dvru_req_t r);
      pending_results.push_back(route_table_update(r));
    endfunction

    function void write_reg(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
      if (a == REG_COST_LIMIT) cost_limit = d[COST_W-1:0];
    endfunction

    task check_reg(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
      if (a == REG_COST_LIMIT && d !== PDATA_W'(cost_limit))
        report("cost_limit read-back", d, PDATA_W'(cost_limit));
    endtask

    task check_result(dvru_rsp_t got);
      dvru_rsp_t want;
      if (pending_results.size() == 0) begin
        report("result word with nothing outstanding", got.next_hop_addr, '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.outcome !== want.outcome)
        report("outcome", ADDR_W'(got.outcome), ADDR_W'(want.outcome));
      if (got.changed !== want.changed)
        report("changed", ADDR_W'(got.changed), ADDR_W'(want.changed));
      if (got.next_hop_addr !== want.next_hop_addr)
        report("next_hop_addr", got.next_hop_addr, want.next_hop_addr);
      if (got.route_cost !== want.route_cost)
        report("route_cost", ADDR_W'(got.route_cost), ADDR_W'(want.route_cost));
      if (got.purged_count !== want.purged_count)
        report("purged_count", ADDR_W'(got.purged_count), ADDR_W'(want.purged_count));
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  dvru_req_t          req = '0;
  logic               done;
  dvru_rsp_t          rsp;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  route_table_scoreboard route_sb = new();
  int                    idle_pct = 6;
  int                    stalled_cycles = 0;
  logic [ADDR_W-1:0]     dest_pool [DEST_POOL];
  logic [ADDR_W-1:0]     hop_pool [HOP_POOL];

  distance_vector_route_update dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Everything is sampled at the rising edge, before the block's own updates land.
  // Result words are checked before the accepted item is noted; the queue keeps them
  // apart anyway, since a word shown with an accept belongs to the previous item.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) route_sb.check_result(rsp);
      if (start && !busy) route_sb.note_item(req);
      if (psel && penable && pready) begin
        if (pwrite) route_sb.write_reg(paddr, pwdata);
        else route_sb.check_reg(paddr, prdata);
      end
      if (done || (start && !busy) || (psel && penable && pready)) stalled_cycles = 0;
      else stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("[%0t] no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("distance_vector_route_update verification failed");
        $finish;
      end
    end
  end

  // One configuration access: setup cycle, then access until pready. The trailing
  // cycle keeps a following access from lowering and raising psel in one step.
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                            input logic [PDATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Presents one item and returns at the edge that accepts it. start stays high so a
  // following item can go back to back; a random gap lowers it first.
  task automatic send_item(input dvru_req_t r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Lets every outstanding word arrive so the register can be touched safely.
  task automatic drain();
    @(posedge clk);
    while (route_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic dvru_req_t make_item(logic [1:0] k, logic [ADDR_W-1:0] hop,
                                          logic [COST_W-1:0] lc, logic [ADDR_W-1:0] d,
                                          logic [COST_W-1:0] adv);
    dvru_req_t r;
    r.kind = k;
    r.neighbor_addr = hop;
    r.link_metric = lc;
    r.dest_addr = d;
    r.advertised_distance = adv;
    return r;
  endfunction

  // Mostly advertisements over a small set of destinations and neighbors, so routes
  // get updated, replaced and looked up; a few fresh addresses help fill the table.
  function automatic dvru_req_t random_item();
    dvru_req_t r;
    int        pick;
    r.neighbor_addr = ($urandom_range(9) == 0) ? $urandom() : hop_pool[$urandom_range(HOP_POOL - 1)];
    r.dest_addr = ($urandom_range(9) == 0) ? $urandom() : dest_pool[$urandom_range(DEST_POOL - 1)];
    r.link_metric = ($urandom_range(3) == 0) ? COST_W'($urandom_range(255))
                                             : COST_W'($urandom_range(12));
    r.advertised_distance = ($urandom_range(3) == 0) ? COST_W'($urandom_range(255))
                                                     : COST_W'($urandom_range(12));
    pick = $urandom_range(99);
    if (pick < 68) r.kind = KIND_RELAX;
    else if (pick < 88) r.kind = KIND_LOOKUP;
    else if (pick < 97) r.kind = KIND_PURGE;
    else r.kind = KIND_UNUSED;
    return r;
  endfunction

  localparam logic [ADDR_W-1:0] DEST_A = 32'h0A00_0001;
  localparam logic [ADDR_W-1:0] HOP_1  = 32'hC0A8_0001;
  localparam logic [ADDR_W-1:0] HOP_2  = 32'hC0A8_0002;

  initial begin
    dvru_req_t         directed [$];
    logic [COST_W-1:0] phase_limit [8];
    int                phase_items [8];

    foreach (dest_pool[i]) dest_pool[i] = $urandom();
    foreach (hop_pool[i]) hop_pool[i] = $urandom();
    dest_pool[0] = '0;
    dest_pool[1] = '1;
    hop_pool[0] = '0;
    hop_pool[1] = '1;

    // The limit is raised first so the table fills, then lowered under stored costs,
    // taken to zero (everything unreachable), and swept through other values.
    phase_limit = '{8'd255, 8'd1, 8'd0, 8'd16, 8'd200, 8'($urandom_range(1, 255)), 8'd8, 8'd255};
    phase_items = '{80, 40, 30, 60, 50, 50, 50, 40};

    // Directed part at the reset limit of 16, on an empty table.
    directed.push_back(make_item(KIND_LOOKUP, '0, '0, '0, '0));           // miss when empty
    directed.push_back(make_item(KIND_PURGE, '0, '0, '0, '0));            // nothing to purge
    directed.push_back(make_item(KIND_UNUSED, '1, '1, '1, '1));           // unused kind
    directed.push_back(make_item(KIND_RELAX, HOP_1, 8'd3, DEST_A, 8'd4)); // insert at 7
    directed.push_back(make_item(KIND_RELAX, HOP_1, 8'd3, DEST_A, 8'd4)); // same hop, same cost
    directed.push_back(make_item(KIND_RELAX, HOP_1, 8'd1, DEST_A, 8'd2)); // cost updated
    directed.push_back(make_item(KIND_RELAX, HOP_2, 8'd5, DEST_A, 8'd5)); // other hop, no gain
    directed.push_back(make_item(KIND_RELAX, HOP_2, 8'd0, DEST_A, 8'd0)); // replaced at 0
    directed.push_back(make_item(KIND_RELAX, HOP_2, '1, DEST_A, '1));     // 510 saturates
    directed.push_back(make_item(KIND_LOOKUP, '0, '0, DEST_A, '0));       // hit at the limit
    directed.push_back(make_item(KIND_RELAX, '1, 8'd10, '1, 8'd6));       // unknown, unreachable
    directed.push_back(make_item(KIND_RELAX, '1, 8'd15, '1, 8'd0));       // insert just below
    directed.push_back(make_item(KIND_RELAX, '0, 8'd0, '0, 8'd0));        // insert at zero
    directed.push_back(make_item(KIND_LOOKUP, '0, '0, '1, '0));
    directed.push_back(make_item(KIND_LOOKUP, '1, '1, '0, '1));
    directed.push_back(make_item(KIND_RELAX, '0, '1, '0, '0));            // same hop, saturated
    directed.push_back(make_item(KIND_PURGE, '0, '0, '0, '0));            // removes two routes
    directed.push_back(make_item(KIND_LOOKUP, '0, '0, DEST_A, '0));       // gone after purge
    directed.push_back(make_item(KIND_RELAX, HOP_1, 8'd0, '0, 8'd255));   // unknown again

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_item(directed[i]);
    start <= 1'b0;
    drain();

    foreach (phase_limit[p]) begin
      apb_access(1'b1, REG_COST_LIMIT, PDATA_W'(phase_limit[p]));
      apb_access(1'b0, REG_COST_LIMIT, '0);
      // One phase runs without any sender gaps at all.
      idle_pct = (p == 3) ? 0 : 6;
      repeat (phase_items[p]) send_item(random_item());
      start <= 1'b0;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (route_sb.fail_count == 0) begin
      $display("distance_vector_route_update verification clean");
    end else begin
      $display("distance_vector_route_update verification failed");
    end
    $finish;
  end

endmodule
